### hdl/skinny_pkg.sv
// Shared types, constants and the S-box for the SKINNY-128-384 round chain.
package skinny_pkg;

  localparam int ROUNDS      = 56;
  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
  localparam int RC_BITS     = 6;

  // Tweakey cell permutation: new cell i takes old cell TK_PERM[i].
  localparam logic [3:0] TK_PERM [BLOCK_BYTES] = '{
    4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
    4'd0, 4'd1,  4'd2, 4'd3,  4'd4,  4'd5,  4'd6,  4'd7
  };

  // Data handed from one round cell to the next.
  typedef struct packed {
    logic [BLOCK_BITS-1:0] s;
    logic [BLOCK_BITS-1:0] k1;
    logic [BLOCK_BITS-1:0] k2;
    logic [BLOCK_BITS-1:0] k3;
    logic [RC_BITS-1:0]    rc;
  } stage_t;

  function automatic logic [7:0] sbox8(input logic [7:0] xi);
    logic [7:0] x;
    x = xi;
    for (int it = 0; it < 4; it++) begin
      if ((x[7] | x[6]) == 1'b0) x[4] = ~x[4];
      if ((x[3] | x[2]) == 1'b0) x[0] = ~x[0];
      if (it < 3) begin
        x = {x[2], x[1], x[7], x[6], x[4], x[0], x[3], x[5]};
      end else begin
        x = {x[7:3], x[1], x[2], x[0]};
      end
    end
    return x;
  endfunction

endpackage

### hdl/skinny_128_384_encrypt_core.sv
// SKINNY-128-384 encryption core: a chain of ROUNDS round cells, one per round.
// An accepted word moves through the round-cell registers in order to become its ciphertext word.
// Throughput: one word per cycle while the output is not stalled; each round cell holds one word in flight.
// A stalled output freezes the whole chain; in_ready = !out_valid || out_ready.
// The last cell's register is the output register.
// Reset (rst, synchronous) clears every cell's valid bit; payload is not reset.
module skinny_128_384_encrypt_core import skinny_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] plaintext_hi,
  input  logic [63:0] plaintext_lo,
  input  logic [63:0] tk1_hi,
  input  logic [63:0] tk1_lo,
  input  logic [63:0] tk2_hi,
  input  logic [63:0] tk2_lo,
  input  logic [63:0] tk3_hi,
  input  logic [63:0] tk3_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] ciphertext_hi,
  output logic [63:0] ciphertext_lo
);

  stage_t chain_data  [ROUNDS+1];
  logic   chain_valid [ROUNDS+1];
  logic   en;

  assign en       = !chain_valid[ROUNDS] || out_ready;
  assign in_ready = en;

  assign chain_valid[0]   = in_valid;
  assign chain_data[0].s  = {plaintext_hi, plaintext_lo};
  assign chain_data[0].k1 = {tk1_hi, tk1_lo};
  assign chain_data[0].k2 = {tk2_hi, tk2_lo};
  assign chain_data[0].k3 = {tk3_hi, tk3_lo};
  assign chain_data[0].rc = '0;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    skinny_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[r]),
      .in_data   (chain_data[r]),
      .out_valid (chain_valid[r+1]),
      .out_data  (chain_data[r+1])
    );
  end

  assign out_valid     = chain_valid[ROUNDS];
  assign ciphertext_hi = chain_data[ROUNDS].s[BLOCK_BITS-1 -: 64];
  assign ciphertext_lo = chain_data[ROUNDS].s[63:0];

endmodule

### hdl/skinny_cell.sv
// One SKINNY round cell: full round plus tweakey schedule, registered output.
module skinny_cell import skinny_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   out_valid,
  output stage_t out_data
);

  stage_t data_next;

  always_comb begin
    logic [7:0] s  [BLOCK_BYTES];
    logic [7:0] t  [BLOCK_BYTES];
    logic [7:0] k1 [BLOCK_BYTES];
    logic [7:0] k2 [BLOCK_BYTES];
    logic [7:0] k3 [BLOCK_BYTES];
    logic [7:0] p1 [BLOCK_BYTES];
    logic [7:0] p2 [BLOCK_BYTES];
    logic [7:0] p3 [BLOCK_BYTES];
    logic [RC_BITS-1:0] rc;

    rc = {in_data.rc[RC_BITS-2:0], in_data.rc[5] ^ in_data.rc[4] ^ 1'b1};

    for (int i = 0; i < BLOCK_BYTES; i++) begin
      s[i]  = sbox8(in_data.s[BLOCK_BITS-1-8*i -: 8]);
      k1[i] = in_data.k1[BLOCK_BITS-1-8*i -: 8];
      k2[i] = in_data.k2[BLOCK_BITS-1-8*i -: 8];
      k3[i] = in_data.k3[BLOCK_BITS-1-8*i -: 8];
    end

    s[0] = s[0] ^ {4'b0000, rc[3:0]};
    s[4] = s[4] ^ {6'b000000, rc[5:4]};
    s[8] = s[8] ^ 8'h02;

    // round tweakey covers the first two rows only
    for (int i = 0; i < 8; i++) begin
      s[i] = s[i] ^ k1[i] ^ k2[i] ^ k3[i];
    end

    for (int i = 0; i < BLOCK_BYTES; i++) begin
      p1[i] = k1[TK_PERM[i]];
      p2[i] = k2[TK_PERM[i]];
      p3[i] = k3[TK_PERM[i]];
    end
    for (int i = 0; i < 8; i++) begin
      p2[i] = {p2[i][6:0], p2[i][7] ^ p2[i][5]};
      p3[i] = {p3[i][0] ^ p3[i][6], p3[i][7:1]};
    end

    // ShiftRows, rows rotated right
    t[0]  = s[0];  t[1]  = s[1];  t[2]  = s[2];  t[3]  = s[3];
    t[4]  = s[7];  t[5]  = s[4];  t[6]  = s[5];  t[7]  = s[6];
    t[8]  = s[10]; t[9]  = s[11]; t[10] = s[8];  t[11] = s[9];
    t[12] = s[13]; t[13] = s[14]; t[14] = s[15]; t[15] = s[12];

    for (int c = 0; c < 4; c++) begin
      s[c]      = t[c] ^ t[8+c] ^ t[12+c];
      s[4+c]    = t[c];
      s[8+c]    = t[4+c] ^ t[8+c];
      s[12+c]   = t[c] ^ t[8+c];
    end

    for (int i = 0; i < BLOCK_BYTES; i++) begin
      data_next.s[BLOCK_BITS-1-8*i -: 8]  = s[i];
      data_next.k1[BLOCK_BITS-1-8*i -: 8] = p1[i];
      data_next.k2[BLOCK_BITS-1-8*i -: 8] = p2[i];
      data_next.k3[BLOCK_BITS-1-8*i -: 8] = p3[i];
    end
    data_next.rc = rc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule
